FILE: sv/rwst_pkg.sv
// Shared types, constants and helper functions for the read/write set tracker.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package rwst_pkg;

    localparam int MAX_THREADS    = 16;
    localparam int TABLE_ENTRIES  = 64;
    localparam int LINE_ADDR_BITS = 32;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int MASK_W = 16;
    localparam int CNT_W  = 5;
    localparam int TID_W  = 4;
    localparam int ADDR_W = 32;

    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [MASK_W-1:0]         mask_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [TID_W-1:0]          tid_t;
    typedef logic [LINE_ADDR_BITS-1:0] line_t;

    localparam cnt_t ACTIVE_THREADS_RST = cnt_t'(16);
    localparam cnt_t MAX_THREADS_C      = cnt_t'(MAX_THREADS);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } op_e;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_BAD_THREAD = 2'd2
    } status_e;

    // Request payload as it crosses the input channel.
    typedef struct packed {
        logic [1:0]        operation;
        tid_t              thread_id;
        logic [ADDR_W-1:0] line_addr;
    } req_t;

    // Result payload as it crosses the output channel.
    typedef struct packed {
        cnt_t       reader_count;
        cnt_t       writer_count;
        mask_t      reader_mask;
        mask_t      writer_mask;
        logic [1:0] status;
    } rsp_t;

    // Request and allocation command seen by every cell at once.
    typedef struct packed {
        op_e   op;
        tid_t  tid;
        line_t line;
        logic  ok;
        logic  alloc_en;
        idx_t  alloc_idx;
    } cell_cmd_t;

    // Token handed from cell to cell while a request walks the table.
    typedef struct packed {
        logic  vld;
        logic  hit;
        logic  free_found;
        idx_t  free_idx;
        mask_t rd;
        mask_t wr;
    } token_t;

    localparam logic [2:0] NIB_CNT [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
    };

    function automatic cnt_t popcount(input mask_t v);
        cnt_t s;
        s = cnt_t'(NIB_CNT[v[3:0]])   + cnt_t'(NIB_CNT[v[7:4]])
          + cnt_t'(NIB_CNT[v[11:8]])  + cnt_t'(NIB_CNT[v[15:12]]);
        return s;
    endfunction

    function automatic mask_t tid_bit(input tid_t t);
        return mask_t'(1) << t;
    endfunction

endpackage

`default_nettype wire

FILE: sv/tm_read_write_set_tracker_core.sv
// Top level of the transactional read/write set tracker: request control,
// result buffering and the row of directory cells. Depends on rwst_pkg, rwst_cell.
//
//   channel | signals                   | direction | accepted when
//   --------+---------------------------+-----------+------------------------
//   request | req_valid req_ready req   | in        | req_valid & req_ready
//   result  | rsp_valid rsp_ready rsp   | out       | rsp_valid & rsp_ready
//   config  | cfg_we cfg_wdata          | in        | cfg_we (no wait)
//
// Each request walks the row of TABLE_ENTRIES cells one cell per cycle; the
// result is registered into the output slot when the token leaves the last
// cell, and the next request is taken only after that. One request is in
// the row at a time.
// Reset empties every entry and sets active_threads to 16; no clearing pass.
// A finished result waits in the output register, with one spare slot behind
// it, so the next request is taken while the result is still unread.
`default_nettype none

module tm_read_write_set_tracker_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire rwst_pkg::req_t        req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output rwst_pkg::rsp_t             rsp,
    input  wire logic                  cfg_we,
    input  wire rwst_pkg::cnt_t        cfg_wdata
);

    localparam int N = rwst_pkg::TABLE_ENTRIES;

    // Configuration and control state
    rwst_pkg::cnt_t     thr_reg;
    logic               busy_reg;
    logic               start_reg;
    logic               out_vld_reg;
    logic               pend_vld_reg;

    // Payload state
    rwst_pkg::cell_cmd_t cmd_reg;
    rwst_pkg::rsp_t      out_reg;
    rwst_pkg::rsp_t      pend_reg;

    rwst_pkg::cnt_t     limit;
    logic               accept;
    logic               done;
    logic               out_free;
    logic               alloc_en;
    rwst_pkg::cell_cmd_t cmd;
    rwst_pkg::rsp_t     res;
    rwst_pkg::mask_t    res_rd;
    rwst_pkg::mask_t    res_wr;
    rwst_pkg::status_e  res_st;

    rwst_pkg::token_t   tok [N+1];
    logic [N:0]         tok_vld;
    rwst_pkg::token_t   tail;

    assign accept    = req_valid && req_ready;
    assign req_ready = !busy_reg && !pend_vld_reg;

    // Clamp the thread limit to what the masks can hold.
    assign limit = (thr_reg > rwst_pkg::MAX_THREADS_C) ? rwst_pkg::MAX_THREADS_C : thr_reg;

    // Head of the row: a fresh token carries no hit and no free entry.
    always_comb
    begin
        tok[0]     = '0;
        tok[0].vld = start_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            rwst_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .idx     (rwst_pkg::idx_t'(gi)),
                .cmd     (cmd),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1])
            );
        end
        for (gi = 0; gi <= N; gi++)
        begin : g_vld
            assign tok_vld[gi] = tok[gi].vld;
        end
    endgenerate

    assign tail = tok[N];
    assign done = tail.vld;

    // Allocate the lowest free entry when a valid record found no match.
    assign alloc_en = done && cmd_reg.ok && !tail.hit && tail.free_found &&
                      ((cmd_reg.op == rwst_pkg::OP_READ) || (cmd_reg.op == rwst_pkg::OP_WRITE));

    always_comb
    begin
        cmd           = cmd_reg;
        cmd.alloc_en  = alloc_en;
        cmd.alloc_idx = tail.free_idx;
    end

    // Build the result once the token leaves the last cell.
    always_comb
    begin
        res_rd = '0;
        res_wr = '0;
        res_st = rwst_pkg::ST_OK;
        unique case (cmd_reg.op) inside
            rwst_pkg::OP_CLEAR:
            begin
                res_st = cmd_reg.ok ? rwst_pkg::ST_OK : rwst_pkg::ST_BAD_THREAD;
            end
            rwst_pkg::OP_QUERY:
            begin
                res_rd = tail.rd;
                res_wr = tail.wr;
            end
            rwst_pkg::OP_READ, rwst_pkg::OP_WRITE:
            begin
                if (!cmd_reg.ok)
                begin
                    res_rd = tail.rd;
                    res_wr = tail.wr;
                    res_st = rwst_pkg::ST_BAD_THREAD;
                end
                else if (tail.hit)
                begin
                    res_rd = tail.rd;
                    res_wr = tail.wr;
                end
                else if (tail.free_found)
                begin
                    res_rd = (cmd_reg.op == rwst_pkg::OP_READ)
                             ? rwst_pkg::tid_bit(cmd_reg.tid) : '0;
                    res_wr = (cmd_reg.op == rwst_pkg::OP_WRITE)
                             ? rwst_pkg::tid_bit(cmd_reg.tid) : '0;
                end
                else
                begin
                    res_st = rwst_pkg::ST_FULL;
                end
            end
            default:
            begin
                res_st = rwst_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        res.reader_count = rwst_pkg::popcount(res_rd);
        res.writer_count = rwst_pkg::popcount(res_wr);
        res.reader_mask  = res_rd;
        res.writer_mask  = res_wr;
        res.status       = res_st;
    end

    assign out_free = !out_vld_reg || rsp_ready;

    // Control: hold the thread limit, advance the request, move results along.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= rwst_pkg::ACTIVE_THREADS_RST;
            busy_reg     <= 1'b0;
            start_reg    <= 1'b0;
            out_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            start_reg <= accept;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end

            if (out_free)
            begin
                if (pend_vld_reg)
                begin
                    out_vld_reg  <= 1'b1;
                    pend_vld_reg <= done;
                end
                else
                begin
                    out_vld_reg <= done;
                end
            end
            else if (done)
            begin
                pend_vld_reg <= 1'b1;
            end
        end
    end

    // Payload: capture the request, then the result into output or spare slot.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.op        <= rwst_pkg::op_e'(req.operation);
            cmd_reg.tid       <= req.thread_id;
            cmd_reg.line      <= req.line_addr[rwst_pkg::LINE_ADDR_BITS-1:0];
            cmd_reg.ok        <= (rwst_pkg::cnt_t'(req.thread_id) < limit);
            cmd_reg.alloc_en  <= 1'b0;
            cmd_reg.alloc_idx <= '0;
        end
        if (out_free)
        begin
            if (pend_vld_reg)
            begin
                out_reg <= pend_reg;
                if (done)
                begin
                    pend_reg <= res;
                end
            end
            else if (done)
            begin
                out_reg <= res;
            end
        end
        else if (done)
        begin
            pend_reg <= res;
        end
    end

    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

`ifndef ASSERT_OFF
    // At most one request token travels the row.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vld))
        else $error("more than one token in the cell row");

    // A result never completes while the spare slot is occupied.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !pend_vld_reg)
        else $error("result finished with spare slot full");

    // A token in the row implies the block is busy.
    a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_vld != '0) |-> busy_reg)
        else $error("token in row while block idle");

    // A dropped record reports empty masks.
    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == rwst_pkg::ST_FULL) |->
            (rsp.reader_mask == '0 && rsp.writer_mask == '0))
        else $error("full status with non-empty masks");
`endif

endmodule

`default_nettype wire

FILE: sv/rwst_cell.sv
// One directory entry of the tracker: line address plus reader and writer masks.
// Depends on rwst_pkg for the command, token and mask types.
`default_nettype none

module rwst_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rwst_pkg::idx_t     idx,
    input  wire rwst_pkg::cell_cmd_t cmd,
    input  wire rwst_pkg::token_t   tok_in,
    output rwst_pkg::token_t        tok_out
);

    logic              valid_reg, valid_next;
    rwst_pkg::line_t   line_reg, line_next;
    rwst_pkg::mask_t   rd_reg, rd_next;
    rwst_pkg::mask_t   wr_reg, wr_next;
    rwst_pkg::token_t  tok_reg, tok_next;

    logic              hit;
    rwst_pkg::mask_t   bit_m;
    rwst_pkg::mask_t   rd_upd;
    rwst_pkg::mask_t   wr_upd;

    assign hit   = valid_reg && (line_reg == cmd.line);
    assign bit_m = rwst_pkg::tid_bit(cmd.tid);

    always_comb
    begin
        rd_upd = rd_reg;
        wr_upd = wr_reg;
        if (cmd.ok && cmd.op == rwst_pkg::OP_READ)
        begin
            rd_upd = rd_reg | bit_m;
        end
        if (cmd.ok && cmd.op == rwst_pkg::OP_WRITE)
        begin
            wr_upd = wr_reg | bit_m;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        line_next  = line_reg;
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        tok_next   = tok_in;

        if (tok_in.vld)
        begin
            unique case (cmd.op) inside
                rwst_pkg::OP_CLEAR:
                begin
                    if (cmd.ok && valid_reg)
                    begin
                        rd_next = rd_reg & ~bit_m;
                        wr_next = wr_reg & ~bit_m;
                        if ((rd_next == '0) && (wr_next == '0))
                        begin
                            valid_next = 1'b0;
                        end
                    end
                end
                rwst_pkg::OP_READ, rwst_pkg::OP_WRITE:
                begin
                    if (hit)
                    begin
                        rd_next      = rd_upd;
                        wr_next      = wr_upd;
                        tok_next.hit = 1'b1;
                        tok_next.rd  = rd_upd;
                        tok_next.wr  = wr_upd;
                    end
                    else if (!valid_reg && !tok_in.free_found)
                    begin
                        tok_next.free_found = 1'b1;
                        tok_next.free_idx   = idx;
                    end
                end
                rwst_pkg::OP_QUERY:
                begin
                    if (hit)
                    begin
                        tok_next.hit = 1'b1;
                        tok_next.rd  = rd_reg;
                        tok_next.wr  = wr_reg;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end

        // Claim this entry for a new line once the walk found no match.
        if (cmd.alloc_en && (cmd.alloc_idx == idx))
        begin
            valid_next = 1'b1;
            line_next  = cmd.line;
            rd_next    = (cmd.op == rwst_pkg::OP_READ)  ? bit_m : '0;
            wr_next    = (cmd.op == rwst_pkg::OP_WRITE) ? bit_m : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
